[rtl/bbpi_pkg.sv]
// Package for the buck-boost PI PWM controller: widths, constants,
// register indexes, sequencer states and the scaling span table.
// No dependencies.
`default_nettype none

package bbpi_pkg;

    // Field widths
    localparam int INTEGRAL_WIDTH = 32;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int RAW_W          = 12;
    localparam int VOLT_W         = 13;
    localparam int ERR_W          = 14;
    localparam int GAIN_W         = 16;
    localparam int CMP_W          = 10;
    localparam int TH_W           = 13;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    // Shared multiplier operand widths
    localparam int MUL_A_W = ((INTEGRAL_WIDTH > 25) ? INTEGRAL_WIDTH : 25) + 1;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Divide by 4095: q ~ (x * 4097) >> 24, then one correction step
    localparam int RAW_FULL       = 4095;
    localparam int RECIP_RAW      = 4097;
    localparam int RAW_QUOT_SHIFT = 24;
    localparam int RAW_X_W        = 26;

    // Divide by 600: q = (x * ceil(2^30 / 600)) >> 30, exact for x < 2^20
    localparam int DRIVE_TOP        = 600;
    localparam int DRIVE_QUOT_SHIFT = 30;
    localparam int RECIP_DRIVE      = ((1 << DRIVE_QUOT_SHIFT) + DRIVE_TOP - 1) / DRIVE_TOP;
    localparam int MAP_X_W          = 20;

    localparam int COMPARE_TOP = 1023;

    // Register reset values
    localparam int GAIN_RESET     = ((1 << GAIN_FRAC_BITS) + 5) / 10;
    localparam int OFFSET_RESET   = 500;
    localparam int LIMIT_RESET    = COMPARE_TOP - 256;
    localparam int UNDER_TH_RESET = 1000;
    localparam int OVER_TH_RESET  = 2500;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REVERSE    = 3'd0,
        CFG_PROP_GAIN  = 3'd1,
        CFG_INTEG_GAIN = 3'd2,
        CFG_OFFSET     = 3'd3,
        CFG_PWM_LIMIT  = 3'd4,
        CFG_UNDER_TH   = 3'd5,
        CFG_OVER_TH    = 3'd6
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCL_MUL,
        ST_SCL_RCP,
        ST_SCL_FIX,
        ST_ERR,
        ST_PI_P,
        ST_PI_I,
        ST_PI_SUM,
        ST_OFFSET,
        ST_MAP_MUL,
        ST_MAP_DIV,
        ST_MAP_FIX,
        ST_OUT
    } state_t;

    // Full-scale span of each sample: setpoint, side A, side B
    function automatic logic [VOLT_W-1:0] scale_span(input logic [1:0] sel);
        logic [VOLT_W-1:0] span;
        case (sel)
            2'd0:    span = VOLT_W'(2500);
            2'd1:    span = VOLT_W'(3630);
            2'd2:    span = VOLT_W'(5183);
            default: span = '0;
        endcase
        return span;
    endfunction

endpackage

`default_nettype wire

[rtl/bbpi_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on bbpi_pkg for operand widths.
`default_nettype none

module bbpi_mul (
    input  wire logic                                 aclk,
    input  wire logic signed [bbpi_pkg::MUL_A_W-1:0] op_a,
    input  wire logic signed [bbpi_pkg::MUL_B_W-1:0] op_b,
    output logic signed [bbpi_pkg::PROD_W-1:0]       prod_reg
);
    import bbpi_pkg::*;

    // One product per cycle, always registered before use
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

`default_nettype wire

[rtl/buck_boost_pi_pwm_controller_core.sv]
// Buck-boost PI controller with PWM compare outputs, top level.
// One request is processed at a time: the single shared multiplier is stepped
// through scaling, PI and mapping before the next request is taken.
// A new request is taken while a finished result still waits on m_ready.
// Reset (aresetn low, synchronous) loads the register defaults, clears the
// integral and drops m_valid. Depends on bbpi_pkg and bbpi_mul.
`default_nettype none

module buck_boost_pi_pwm_controller_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bbpi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bbpi_pkg::CFG_DATA_W-1:0]     cfg_data,
    // sample requests
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [bbpi_pkg::RAW_W-1:0]          s_setpoint_raw,
    input  wire logic [bbpi_pkg::RAW_W-1:0]          s_side_a_raw,
    input  wire logic [bbpi_pkg::RAW_W-1:0]          s_side_b_raw,
    // results
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [bbpi_pkg::CMP_W-1:0]               m_compare_ch1,
    output logic [bbpi_pkg::CMP_W-1:0]               m_compare_ch2,
    output logic                                     m_under_voltage,
    output logic                                     m_over_voltage
);
    import bbpi_pkg::*;

    // Configuration registers
    logic              reverse_reg;
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [CMP_W-1:0]  offset_reg;
    logic [CMP_W-1:0]  limit_reg;
    logic [TH_W-1:0]   under_th_reg;
    logic [TH_W-1:0]   over_th_reg;

    // Sequencer
    state_t     state_reg, state_next;
    logic [1:0] cnt_reg;

    // Datapath
    logic [RAW_W-1:0]                setpoint_reg, side_a_reg, side_b_reg;
    logic [RAW_X_W-1:0]              x_reg;
    logic [VOLT_W-1:0]               vref_reg, va_reg, vb_reg;
    logic signed [ERR_W-1:0]         err_reg;
    logic signed [INTEGRAL_WIDTH-1:0] integral_reg, sum_reg;
    logic                            under_reg, over_reg;
    logic signed [PROD_W-1:0]        acc_reg, drive_reg, boost_reg;
    logic                            cls_hi_reg, cls_lo_reg;
    logic [CMP_W-1:0]                pbuck_reg, pboost_reg;
    logic                            m_valid_reg;
    logic [CMP_W-1:0]                ch1_reg, ch2_reg;
    logic                            uv_reg, ov_reg;

    // Multiplier interface
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    bbpi_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    // Combinational helpers
    logic [RAW_W-1:0]                raw_sel;
    logic [VOLT_W-1:0]               q_est, q_fix;
    logic [RAW_X_W-1:0]              rem;
    logic [VOLT_W-1:0]               vin, vout;
    logic signed [ERR_W-1:0]         err_calc;
    logic signed [INTEGRAL_WIDTH:0]  sum_wide;
    logic signed [INTEGRAL_WIDTH-1:0] sum_sat;
    logic signed [PROD_W-1:0]        acc_sum, d_sel;
    logic                            d_neg, d_hi;
    logic [CMP_W-1:0]                map_val;
    logic                            out_load;

    always_comb begin
        // sample chosen by the scaling counter
        case (cnt_reg)
            2'd0:    raw_sel = setpoint_reg;
            2'd1:    raw_sel = side_a_reg;
            default: raw_sel = side_b_reg;
        endcase

        // divide by 4095 correction: estimate is exact or one low
        q_est = prod_reg[RAW_QUOT_SHIFT +: VOLT_W];
        rem   = x_reg - {q_est, 12'b0} + RAW_X_W'(q_est);
        q_fix = (rem >= RAW_X_W'(RAW_FULL)) ? q_est + VOLT_W'(1) : q_est;

        // error and saturating integral
        vin      = reverse_reg ? vb_reg : va_reg;
        vout     = reverse_reg ? va_reg : vb_reg;
        err_calc = $signed({1'b0, vref_reg}) - $signed({1'b0, vout});
        sum_wide = (INTEGRAL_WIDTH+1)'(integral_reg) + (INTEGRAL_WIDTH+1)'(err_calc);
        if (sum_wide[INTEGRAL_WIDTH] != sum_wide[INTEGRAL_WIDTH-1]) begin
            sum_sat = sum_wide[INTEGRAL_WIDTH]
                    ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
                    : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[INTEGRAL_WIDTH-1:0];
        end

        // PI sum
        acc_sum = acc_reg + prod_reg;

        // drive classification for the clamp map
        d_sel = cnt_reg[0] ? boost_reg : drive_reg;
        d_neg = d_sel[PROD_W-1];
        d_hi  = !d_neg && (d_sel[PROD_W-2:0] > (PROD_W-1)'(DRIVE_TOP));

        if (cls_hi_reg) begin
            map_val = limit_reg;
        end else if (cls_lo_reg) begin
            map_val = '0;
        end else begin
            map_val = prod_reg[DRIVE_QUOT_SHIFT +: CMP_W];
        end

        out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_SCL_MUL;
            ST_SCL_MUL: state_next = ST_SCL_RCP;
            ST_SCL_RCP: state_next = ST_SCL_FIX;
            ST_SCL_FIX: state_next = (cnt_reg == 2'd2) ? ST_ERR : ST_SCL_MUL;
            ST_ERR:     state_next = ST_PI_P;
            ST_PI_P:    state_next = ST_PI_I;
            ST_PI_I:    state_next = ST_PI_SUM;
            ST_PI_SUM:  state_next = ST_OFFSET;
            ST_OFFSET:  state_next = ST_MAP_MUL;
            ST_MAP_MUL: state_next = ST_MAP_DIV;
            ST_MAP_DIV: state_next = ST_MAP_FIX;
            ST_MAP_FIX: state_next = (cnt_reg == 2'd1) ? ST_OUT : ST_MAP_MUL;
            ST_OUT:     if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake and multiplier operands
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_SCL_MUL: begin
                mul_a = MUL_A_W'({1'b0, raw_sel});
                mul_b = MUL_B_W'({1'b0, scale_span(cnt_reg)});
            end
            ST_SCL_RCP: begin
                mul_a = MUL_A_W'({1'b0, prod_reg[RAW_X_W-2:0]});
                mul_b = MUL_B_W'(RECIP_RAW);
            end
            ST_PI_P: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'({1'b0, prop_gain_reg});
            end
            ST_PI_I: begin
                mul_a = MUL_A_W'(sum_reg);
                mul_b = MUL_B_W'({1'b0, integ_gain_reg});
            end
            ST_MAP_MUL: begin
                mul_a = MUL_A_W'({1'b0, d_sel[CMP_W-1:0]});
                mul_b = MUL_B_W'({1'b0, limit_reg});
            end
            ST_MAP_DIV: begin
                mul_a = MUL_A_W'({1'b0, prod_reg[MAP_X_W-1:0]});
                mul_b = MUL_B_W'(RECIP_DRIVE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control state, configuration and integral
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
            integral_reg   <= '0;
            reverse_reg    <= 1'b0;
            prop_gain_reg  <= GAIN_W'(GAIN_RESET);
            integ_gain_reg <= GAIN_W'(GAIN_RESET);
            offset_reg     <= CMP_W'(OFFSET_RESET);
            limit_reg      <= CMP_W'(LIMIT_RESET);
            under_th_reg   <= TH_W'(UNDER_TH_RESET);
            over_th_reg    <= TH_W'(OVER_TH_RESET);
        end else begin
            state_reg <= state_next;

            // iteration counter for scaling and mapping passes
            case (state_reg)
                ST_SCL_FIX: cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
                ST_MAP_FIX: cnt_reg <= (cnt_reg == 2'd1) ? 2'd0 : cnt_reg + 2'd1;
                default:    cnt_reg <= cnt_reg;
            endcase

            // integral update, cleared on undervoltage
            if (state_reg == ST_ERR) begin
                integral_reg <= (vin < under_th_reg) ? '0 : sum_sat;
            end

            // result register handshake
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // configuration writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REVERSE:    reverse_reg    <= cfg_data[0];
                    CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN: integ_gain_reg <= cfg_data[GAIN_W-1:0];
                    CFG_OFFSET:     offset_reg     <= cfg_data[CMP_W-1:0];
                    CFG_PWM_LIMIT:  limit_reg      <= cfg_data[CMP_W-1:0];
                    CFG_UNDER_TH:   under_th_reg   <= cfg_data[TH_W-1:0];
                    CFG_OVER_TH:    over_th_reg    <= cfg_data[TH_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // Payload datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    setpoint_reg <= s_setpoint_raw;
                    side_a_reg   <= s_side_a_raw;
                    side_b_reg   <= s_side_b_raw;
                end
            end
            ST_SCL_RCP: x_reg <= prod_reg[RAW_X_W-1:0];
            ST_SCL_FIX: begin
                case (cnt_reg)
                    2'd0:    vref_reg <= q_fix;
                    2'd1:    va_reg   <= q_fix;
                    default: vb_reg   <= q_fix;
                endcase
            end
            ST_ERR: begin
                err_reg   <= err_calc;
                sum_reg   <= sum_sat;
                under_reg <= (vin < under_th_reg);
                over_reg  <= (vin > over_th_reg);
            end
            ST_PI_I:   acc_reg   <= prod_reg;
            ST_PI_SUM: drive_reg <= acc_sum >>> GAIN_FRAC_BITS;
            ST_OFFSET: boost_reg <= drive_reg - $signed({{(PROD_W-CMP_W){1'b0}}, offset_reg});
            ST_MAP_MUL: begin
                cls_hi_reg <= d_hi;
                cls_lo_reg <= d_neg;
            end
            ST_MAP_FIX: begin
                if (cnt_reg[0]) begin
                    pboost_reg <= map_val;
                end else begin
                    pbuck_reg <= map_val;
                end
            end
            default: ;
        endcase

        // result register, channels swapped and inverted in reverse
        if (out_load) begin
            ch1_reg <= reverse_reg ? CMP_W'(COMPARE_TOP) - pboost_reg : pbuck_reg;
            ch2_reg <= reverse_reg ? CMP_W'(COMPARE_TOP) - pbuck_reg : pboost_reg;
            uv_reg  <= under_reg;
            ov_reg  <= over_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_compare_ch1   = ch1_reg;
    assign m_compare_ch2   = ch2_reg;
    assign m_under_voltage = uv_reg;
    assign m_over_voltage  = ov_reg;

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for buck_boost_pi_pwm_controller_core: directed table, then
// random phases at several register settings, results checked against a local predictor.
// Depends on bbpi_pkg and the controller RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bbpi_pkg::*;

    localparam realtime HALF_PERIOD  = 1.0;
    localparam int      RESET_CYCLES = 12;
    localparam int      CYCLE_LIMIT  = 500000;
    localparam int      DRAIN_CYCLES = 50;
    localparam int      HOLD_CYCLES  = 400;
    localparam int      PHASE_ITEMS  = 160;
    localparam int      PHASES       = 6;
    localparam int      PRINT_CAP    = 50;

    // Scaled full-scale values of the three samples
    localparam longint SPAN_SETPOINT = 2500;
    localparam longint SPAN_SIDE_A   = 3630;
    localparam longint SPAN_SIDE_B   = 5183;
    localparam longint INTEG_MAX = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 64'sd1;
    localparam longint INTEG_MIN = -INTEG_MAX - 64'sd1;

    // Index past the end of the register map, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [CMP_W-1:0] ch1;
        logic [CMP_W-1:0] ch2;
        logic             uv;
        logic             ov;
    } pwm_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [RAW_W-1:0]      sp;
        logic [RAW_W-1:0]      a;
        logic [RAW_W-1:0]      b;
        logic                  typed;
        pwm_result_t           want;
    } row_t;

    localparam pwm_result_t NO_RESULT = '0;
    localparam int          NROWS     = 25;

    // Directed rows; typed results only right after reset
    localparam row_t DIRECTED_ROWS [NROWS] = '{
        '{ROW_SAMPLE, '0, '0, 12'd0,    12'd0,    12'd0,    1'b1, '{10'd0, 10'd0, 1'b1, 1'b0}},
        '{ROW_SAMPLE, '0, '0, 12'd4095, 12'd4095, 12'd0,    1'b1, '{10'd639, 10'd0, 1'b0, 1'b1}},
        '{ROW_SAMPLE, '0, '0, 12'd4095, 12'd4095, 12'd4095, 1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd2048, 12'd2048, 12'd2048, 1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd0,    12'd4095, 12'd4095, 1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd4095, 12'd0,    12'd0,    1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd4095, 12'd2000, 12'd0,    1'b0, NO_RESULT},
        '{ROW_WRITE,  CFG_REVERSE, 16'h0001, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd0,    12'd0,    12'd0,    1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd4095, 12'd4095, 12'd0,    1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd4095, 12'd0,    12'd4095, 1'b0, NO_RESULT},
        // upper data bits are dropped, so this returns to forward direction
        '{ROW_WRITE,  CFG_REVERSE,    16'hFFFE, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE,  CFG_PROP_GAIN,  16'hFFFF, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE,  CFG_INTEG_GAIN, 16'h0000, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE,  CFG_OFFSET,     16'hFFFF, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE,  CFG_PWM_LIMIT,  16'hFFFF, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE,  CFG_UNDER_TH,   16'h1FFF, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE,  CFG_OVER_TH,    16'h0000, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd2048, 12'd4095, 12'd1000, 1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd4095, 12'd100,  12'd0,    1'b0, NO_RESULT},
        '{ROW_WRITE,  CFG_UNMAPPED,   16'hFFFF, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE,  CFG_UNDER_TH,   16'h0000, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_WRITE,  CFG_OVER_TH,    16'hFFFF, '0, '0, '0, 1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd4095, 12'd4095, 12'd2048, 1'b0, NO_RESULT},
        '{ROW_SAMPLE, '0, '0, 12'd1,    12'd4095, 12'd4095, 1'b0, NO_RESULT}
    };

    // DUT connections
    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_valid       = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [RAW_W-1:0]      s_setpoint_raw  = '0;
    logic [RAW_W-1:0]      s_side_a_raw    = '0;
    logic [RAW_W-1:0]      s_side_b_raw    = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [CMP_W-1:0]      m_compare_ch1;
    logic [CMP_W-1:0]      m_compare_ch2;
    logic                  m_under_voltage;
    logic                  m_over_voltage;

    // Shadow copy of the controller registers and integrator
    logic                  shadow_reverse    = 1'b0;
    logic [GAIN_W-1:0]     shadow_prop_gain  = GAIN_W'(GAIN_RESET);
    logic [GAIN_W-1:0]     shadow_integ_gain = GAIN_W'(GAIN_RESET);
    logic [CMP_W-1:0]      shadow_offset     = CMP_W'(OFFSET_RESET);
    logic [CMP_W-1:0]      shadow_limit      = CMP_W'(LIMIT_RESET);
    logic [TH_W-1:0]       shadow_under_th   = TH_W'(UNDER_TH_RESET);
    logic [TH_W-1:0]       shadow_over_th    = TH_W'(OVER_TH_RESET);
    longint                integral_acc      = 0;

    pwm_result_t pending_pwm [$];
    pwm_result_t checked_want;
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          cycle_count    = 0;
    int          src_idle_pct   = 32;
    int          sink_idle_pct  = 80;
    bit          hold_arm       = 1'b0;
    bit          hold_taken     = 1'b0;
    int          hold_left      = 0;

    buck_boost_pi_pwm_controller_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_setpoint_raw  (s_setpoint_raw),
        .s_side_a_raw    (s_side_a_raw),
        .s_side_b_raw    (s_side_b_raw),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_compare_ch1   (m_compare_ch1),
        .m_compare_ch2   (m_compare_ch2),
        .m_under_voltage (m_under_voltage),
        .m_over_voltage  (m_over_voltage)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Drive 0..600 maps linearly onto 0..pwm_limit, clamped at both ends
    function automatic logic [CMP_W-1:0] map_drive(input longint drive);
        if (drive > longint'(DRIVE_TOP)) begin
            return shadow_limit;
        end
        if (drive < 0) begin
            return '0;
        end
        return CMP_W'((drive * longint'(shadow_limit)) / longint'(DRIVE_TOP));
    endfunction

    // One control tick: scale, integrate, PI drive, map, flags
    function automatic pwm_result_t predict_controller(input logic [RAW_W-1:0] sp,
                                                       input logic [RAW_W-1:0] a,
                                                       input logic [RAW_W-1:0] b);
        longint      vref, va, vb, vin, vout, err, sum, buck, boost;
        logic [CMP_W-1:0] pbuck, pboost;
        pwm_result_t r;
        vref = (longint'(sp) * SPAN_SETPOINT) / longint'(RAW_FULL);
        va   = (longint'(a) * SPAN_SIDE_A) / longint'(RAW_FULL);
        vb   = (longint'(b) * SPAN_SIDE_B) / longint'(RAW_FULL);
        vin  = shadow_reverse ? vb : va;
        vout = shadow_reverse ? va : vb;
        err  = vref - vout;
        sum  = integral_acc + err;
        if (sum > INTEG_MAX) begin
            sum = INTEG_MAX;
        end
        if (sum < INTEG_MIN) begin
            sum = INTEG_MIN;
        end
        integral_acc = sum;
        // arithmetic shift floors toward minus infinity
        buck = (longint'(shadow_prop_gain) * err + longint'(shadow_integ_gain) * sum)
               >>> GAIN_FRAC_BITS;
        boost  = buck - longint'(shadow_offset);
        pbuck  = map_drive(buck);
        pboost = map_drive(boost);
        if (shadow_reverse) begin
            r.ch1 = CMP_W'(COMPARE_TOP) - pboost;
            r.ch2 = CMP_W'(COMPARE_TOP) - pbuck;
        end else begin
            r.ch1 = pbuck;
            r.ch2 = pboost;
        end
        r.uv = (vin < longint'(shadow_under_th));
        r.ov = (vin > longint'(shadow_over_th));
        // undervoltage dumps the integrator after the outputs are formed
        if (r.uv) begin
            integral_acc = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] mismatch on %s, result %0d: got %0d, want %0d",
                     $realtime, what, results_seen, got, want);
        end
    endtask

    // Register write, only once every pending result is out; enters and leaves at negedge
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (pending_pwm.size() != 0) begin
            @(negedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            CFG_REVERSE:    shadow_reverse    = data[0];
            CFG_PROP_GAIN:  shadow_prop_gain  = data[GAIN_W-1:0];
            CFG_INTEG_GAIN: shadow_integ_gain = data[GAIN_W-1:0];
            CFG_OFFSET:     shadow_offset     = data[CMP_W-1:0];
            CFG_PWM_LIMIT:  shadow_limit      = data[CMP_W-1:0];
            CFG_UNDER_TH:   shadow_under_th   = data[TH_W-1:0];
            CFG_OVER_TH:    shadow_over_th    = data[TH_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_setting(input int rev, kp, ki, offset,
                                 input int limit, under_th, over_th);
        write_register(CFG_REVERSE, CFG_DATA_W'(rev));
        write_register(CFG_PROP_GAIN, CFG_DATA_W'(kp));
        write_register(CFG_INTEG_GAIN, CFG_DATA_W'(ki));
        write_register(CFG_OFFSET, CFG_DATA_W'(offset));
        write_register(CFG_PWM_LIMIT, CFG_DATA_W'(limit));
        write_register(CFG_UNDER_TH, CFG_DATA_W'(under_th));
        write_register(CFG_OVER_TH, CFG_DATA_W'(over_th));
    endtask

    // Offer one sample request; valid only drops when the sender idles
    task automatic push_sample(input logic [RAW_W-1:0] sp, a, b,
                               input logic typed, input pwm_result_t typed_want);
        pwm_result_t predicted;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(negedge aclk);
            end while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid        <= 1'b1;
        s_setpoint_raw <= sp;
        s_side_a_raw   <= a;
        s_side_b_raw   <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = predict_controller(sp, a, b);
        pending_pwm.push_back(typed ? typed_want : predicted);
        @(negedge aclk);
    endtask

    // Result sink: random back-pressure plus one long hold-off
    always @(negedge aclk) begin
        if (hold_arm && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_pwm.size() == 0) begin
                report_mismatch("unexpected result", '0, '0);
            end else begin
                checked_want = pending_pwm.pop_front();
                if (m_compare_ch1 !== checked_want.ch1) begin
                    report_mismatch("compare_ch1", 32'(m_compare_ch1),
                                    32'(checked_want.ch1));
                end
                if (m_compare_ch2 !== checked_want.ch2) begin
                    report_mismatch("compare_ch2", 32'(m_compare_ch2),
                                    32'(checked_want.ch2));
                end
                if (m_under_voltage !== checked_want.uv) begin
                    report_mismatch("under_voltage", 32'(m_under_voltage),
                                    32'(checked_want.uv));
                end
                if (m_over_voltage !== checked_want.ov) begin
                    report_mismatch("over_voltage", 32'(m_over_voltage),
                                    32'(checked_want.ov));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        row_t        row;
        int unsigned sp, a, b, mode;
        longint      span_out;
        int          out_raw;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table
        for (int i = 0; i < NROWS; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_WRITE) begin
                write_register(row.idx, row.data);
            end else begin
                push_sample(row.sp, row.a, row.b, row.typed, row.want);
            end
        end

        // Random phases, each at its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: apply_setting(0, GAIN_RESET, GAIN_RESET, OFFSET_RESET, LIMIT_RESET,
                                 UNDER_TH_RESET, OVER_TH_RESET);
                1: apply_setting(1, $urandom_range(0, 2047), $urandom_range(0, 2047),
                                 $urandom_range(0, 1023), $urandom_range(0, 1023),
                                 $urandom_range(0, 5183), $urandom_range(0, 5183));
                2: apply_setting(0, 65535, 65535, 0, 1023, 0, 5183);
                3: apply_setting(1, 0, 0, 1023, 0, 5183, 0);
                4: apply_setting($urandom_range(0, 1), $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 1023),
                                 $urandom_range(0, 1023), $urandom_range(0, 8191),
                                 $urandom_range(0, 8191));
                default: apply_setting($urandom_range(0, 1), $urandom_range(0, 4095),
                                       $urandom_range(0, 4095), $urandom_range(0, 1023),
                                       $urandom_range(0, 1023), $urandom_range(0, 5183),
                                       $urandom_range(0, 5183));
            endcase
            if (phase < 2) begin
                src_idle_pct  = 32;
                sink_idle_pct = 80;
            end else if (phase < 4) begin
                src_idle_pct  = 80;
                sink_idle_pct = 32;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            // sink stalls for a long stretch while samples keep coming
            if (phase == 1) begin
                hold_arm = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sp   = $urandom_range(0, 4095);
                a    = $urandom_range(0, 4095);
                b    = $urandom_range(0, 4095);
                mode = $urandom_range(0, 3);
                // mostly keep the output side near the setpoint so the loop stays in band
                if (mode != 0) begin
                    span_out = shadow_reverse ? SPAN_SIDE_A : SPAN_SIDE_B;
                    out_raw  = int'((sp * 2500) / span_out) + int'($urandom_range(0, 40)) - 20;
                    if (out_raw < 0) begin
                        out_raw = 0;
                    end
                    if (out_raw > 4095) begin
                        out_raw = 4095;
                    end
                    if (shadow_reverse) begin
                        a = out_raw;
                    end else begin
                        b = out_raw;
                    end
                end
                push_sample(RAW_W'(sp), RAW_W'(a), RAW_W'(b), 1'b0, NO_RESULT);
            end
        end

        // Drain and let the pipeline settle
        s_valid <= 1'b0;
        while (pending_pwm.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
